@@ hdl/ybb_pkg.sv @@
`default_nettype none
package ybb_pkg;

  // Field widths fixed by the interface
  localparam int COORD_WIDTH = 20;
  localparam int FRAC_BITS   = 4;
  localparam int ANGLE_BITS  = 16;

  // Sine/cosine: Q1.15 magnitude up to 1.0, signed
  localparam int TRIG_W = 17;
  localparam int PROD_W = COORD_WIDTH + TRIG_W;
  localparam int ROT_W  = PROD_W + 1;
  localparam int RND_SH = 15;
  localparam int RND_W  = ROT_W - RND_SH;

  localparam int LIMIT_UNITS = 9999;
  localparam logic signed [RND_W-1:0] LIMIT_HI = RND_W'(LIMIT_UNITS * (2 ** FRAC_BITS));
  localparam logic signed [RND_W-1:0] LIMIT_LO = -LIMIT_HI;
  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((2 ** (COORD_WIDTH - 1)) - 1);
  localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic                          box_found;
    logic [ANGLE_BITS-1:0]         yaw_angle;
    logic signed [COORD_WIDTH-1:0] min_x;
    logic signed [COORD_WIDTH-1:0] min_y;
    logic signed [COORD_WIDTH-1:0] max_x;
    logic signed [COORD_WIDTH-1:0] max_y;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] low_x;
    logic signed [COORD_WIDTH-1:0] low_y;
    logic signed [COORD_WIDTH-1:0] high_x;
    logic signed [COORD_WIDTH-1:0] high_y;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] min_x;
    logic signed [COORD_WIDTH-1:0] min_y;
    logic signed [COORD_WIDTH-1:0] max_x;
    logic signed [COORD_WIDTH-1:0] max_y;
  } corner_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
    corner_t                  box;
  } trig_word_t;

  // Rounded rotated coordinates, corner k = 2*i + j (x from i, y from j)
  typedef struct packed {
    logic [3:0][RND_W-1:0] rx;
    logic [3:0][RND_W-1:0] ry;
  } rot_word_t;

endpackage
`default_nettype wire

@@ hdl/yaw_rotated_bounding_box.sv @@
`default_nettype none
// Channel   Direction  Handshake             Word
// in_       input      in_valid / in_stall   ybb_pkg::in_word_t (box, yaw, corners)
// out_      output     out_valid / out_stall ybb_pkg::out_word_t (low/high x and y)
//
// One word per cycle in and out while nothing stalls; a result passes five register
// stages after its input word is taken: index, sine table, multipliers,
// rotate-and-round, bounds.
// A word with box_found low is taken and dropped; it yields no result.
// rst_n is synchronous and active low; it clears the stage valid bits only.
// out_stall holds each full stage with no empty stage after it; empty stages keep filling, so in_stall
// rises only once every stage holds a word.
module yaw_rotated_bounding_box #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ybb_pkg::in_word_t   in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ybb_pkg::out_word_t       out_word
);

  logic                in_rdy;

  // Angle stages to rotation stages
  logic                trig_vld;
  logic                trig_rdy;
  ybb_pkg::trig_word_t trig_word;

  // Rotation stages to bounds stage
  logic                rot_vld;
  logic                rot_rdy;
  ybb_pkg::rot_word_t  rot_word;

  // Take a word whenever the first stage is free or moving on
  assign in_stall = !in_rdy;

  // Quadrant fold and quarter-wave lookup: sine and cosine in Q1.15
  ybb_angle #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_angle (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_valid),
    .in_rdy   (in_rdy),
    .in_word  (in_word),
    .out_vld  (trig_vld),
    .out_rdy  (trig_rdy),
    .out_word (trig_word)
  );

  // Rotate all four corners; products first, then sums rounded half up
  ybb_rotate u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (trig_vld),
    .in_rdy   (trig_rdy),
    .in_word  (trig_word),
    .out_vld  (rot_vld),
    .out_rdy  (rot_rdy),
    .out_word (rot_word)
  );

  // Least and greatest against the +/-9999 unit limits, saturate, drive the port
  ybb_bounds u_bounds (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (rot_vld),
    .in_rdy    (rot_rdy),
    .in_word   (rot_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

@@ hdl/ybb_angle.sv @@
`default_nettype none
module ybb_angle #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_vld,
  output logic                       in_rdy,
  input  wire ybb_pkg::in_word_t     in_word,
  output logic                       out_vld,
  input  wire logic                  out_rdy,
  output ybb_pkg::trig_word_t        out_word
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int POS_W = ybb_pkg::ANGLE_BITS - 2;
  localparam int SCL_W = POS_W + IDX_W;
  localparam int HALF  = 2 ** (ybb_pkg::ANGLE_BITS - 3);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(SINE_TABLE_DEPTH);

  // Quarter-wave sine entry, Q1.15, built by a truncated Taylor series in Q30
  function automatic logic [ybb_pkg::TRIG_W-1:0] sine_entry(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    x    = (64'(i) * 64'd3373259426) / 64'(2 * SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    r = (sum + 64'sd16384) >>> 15;
    if (r > 64'sd32768) begin
      r = 64'sd32768;
    end
    return r[ybb_pkg::TRIG_W-1:0];
  endfunction

  logic [ybb_pkg::TRIG_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];

  always_comb begin
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      sine_rom[i] = sine_entry(i);
    end
  end

  // Stage A: quadrant and table index
  logic                 a_vld_r;
  ybb_pkg::quad_t       a_quad_r;
  logic [IDX_W-1:0]     a_idx_r;
  ybb_pkg::corner_t     a_box_r;
  logic [IDX_W-1:0]     a_idx_nxt;
  logic [SCL_W-1:0]     scaled;
  logic                 a_adv;

  // Stage B: signed sine and cosine
  logic                 b_vld_r;
  ybb_pkg::trig_word_t  b_word_r;
  ybb_pkg::trig_word_t  b_word_nxt;
  logic                 b_adv;
  logic [ybb_pkg::TRIG_W-1:0] u_val;
  logic [ybb_pkg::TRIG_W-1:0] v_val;
  logic signed [ybb_pkg::TRIG_W-1:0] su;
  logic signed [ybb_pkg::TRIG_W-1:0] sv;

  assign b_adv  = !b_vld_r || out_rdy;
  assign a_adv  = !a_vld_r || b_adv;
  assign in_rdy = a_adv;

  always_comb begin
    scaled = SCL_W'(in_word.yaw_angle[POS_W-1:0]) * SCL_W'(SINE_TABLE_DEPTH)
             + SCL_W'(HALF);
    a_idx_nxt = scaled[SCL_W-1:POS_W];
    if (a_idx_nxt > IDX_MAX) begin
      a_idx_nxt = IDX_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_adv) begin
      a_vld_r <= in_vld && in_word.box_found;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && in_vld) begin
      a_quad_r      <= ybb_pkg::quad_t'(in_word.yaw_angle[ybb_pkg::ANGLE_BITS-1 -: 2]);
      a_idx_r       <= a_idx_nxt;
      a_box_r.min_x <= in_word.min_x;
      a_box_r.min_y <= in_word.min_y;
      a_box_r.max_x <= in_word.max_x;
      a_box_r.max_y <= in_word.max_y;
    end
  end

  always_comb begin
    u_val = sine_rom[a_idx_r];
    v_val = sine_rom[IDX_MAX - a_idx_r];
    su    = $signed(u_val);
    sv    = $signed(v_val);
    b_word_nxt.box = a_box_r;
    case (a_quad_r)
      ybb_pkg::QUAD_0: begin
        b_word_nxt.sin_v = su;
        b_word_nxt.cos_v = sv;
      end
      ybb_pkg::QUAD_1: begin
        b_word_nxt.sin_v = sv;
        b_word_nxt.cos_v = -su;
      end
      ybb_pkg::QUAD_2: begin
        b_word_nxt.sin_v = -su;
        b_word_nxt.cos_v = -sv;
      end
      default: begin
        b_word_nxt.sin_v = -sv;
        b_word_nxt.cos_v = su;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_vld_r) begin
      b_word_r <= b_word_nxt;
    end
  end

  assign out_vld  = b_vld_r;
  assign out_word = b_word_r;

endmodule
`default_nettype wire

@@ hdl/ybb_rotate.sv @@
`default_nettype none
module ybb_rotate (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_vld,
  output logic                      in_rdy,
  input  wire ybb_pkg::trig_word_t  in_word,
  output logic                      out_vld,
  input  wire logic                 out_rdy,
  output ybb_pkg::rot_word_t        out_word
);

  localparam int PW = ybb_pkg::PROD_W;
  localparam int RW = ybb_pkg::ROT_W;
  localparam logic signed [RW-1:0] RND_HALF = RW'(2 ** (ybb_pkg::RND_SH - 1));

  // Stage C: eight products, index 0 = min corner, 1 = max corner
  logic                 c_vld_r;
  logic                 c_adv;
  logic signed [PW-1:0] cx_r [2];
  logic signed [PW-1:0] sx_r [2];
  logic signed [PW-1:0] cy_r [2];
  logic signed [PW-1:0] sy_r [2];

  // Stage D: sums and half-up rounding
  logic                 d_vld_r;
  logic                 d_adv;
  ybb_pkg::rot_word_t   d_word_r;
  ybb_pkg::rot_word_t   d_word_nxt;

  assign d_adv  = !d_vld_r || out_rdy;
  assign c_adv  = !c_vld_r || d_adv;
  assign in_rdy = c_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (c_adv) begin
      c_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (c_adv && in_vld) begin
      cx_r[0] <= PW'(in_word.cos_v * in_word.box.min_x);
      cx_r[1] <= PW'(in_word.cos_v * in_word.box.max_x);
      sx_r[0] <= PW'(in_word.sin_v * in_word.box.min_x);
      sx_r[1] <= PW'(in_word.sin_v * in_word.box.max_x);
      cy_r[0] <= PW'(in_word.cos_v * in_word.box.min_y);
      cy_r[1] <= PW'(in_word.cos_v * in_word.box.max_y);
      sy_r[0] <= PW'(in_word.sin_v * in_word.box.min_y);
      sy_r[1] <= PW'(in_word.sin_v * in_word.box.max_y);
    end
  end

  always_comb begin
    logic signed [RW-1:0] sx_sum;
    logic signed [RW-1:0] sy_sum;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        sx_sum = RW'(cx_r[i]) - RW'(sy_r[j]) + RND_HALF;
        sy_sum = RW'(sx_r[i]) + RW'(cy_r[j]) + RND_HALF;
        d_word_nxt.rx[2*i+j] = ybb_pkg::RND_W'(sx_sum >>> ybb_pkg::RND_SH);
        d_word_nxt.ry[2*i+j] = ybb_pkg::RND_W'(sy_sum >>> ybb_pkg::RND_SH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (d_adv) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_adv && c_vld_r) begin
      d_word_r <= d_word_nxt;
    end
  end

  assign out_vld  = d_vld_r;
  assign out_word = d_word_r;

endmodule
`default_nettype wire

@@ hdl/ybb_bounds.sv @@
`default_nettype none
module ybb_bounds (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_vld,
  output logic                     in_rdy,
  input  wire ybb_pkg::rot_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ybb_pkg::out_word_t       out_word
);

  localparam int RW = ybb_pkg::RND_W;
  localparam int CW = ybb_pkg::COORD_WIDTH;

  function automatic logic signed [CW-1:0] sat(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] s;
    s = v;
    if (s > ybb_pkg::SAT_HI) begin
      s = ybb_pkg::SAT_HI;
    end
    if (s < ybb_pkg::SAT_LO) begin
      s = ybb_pkg::SAT_LO;
    end
    return s[CW-1:0];
  endfunction

  logic               e_vld_r;
  logic               e_adv;
  ybb_pkg::out_word_t e_word_r;
  ybb_pkg::out_word_t e_word_nxt;

  assign e_adv  = !e_vld_r || !out_stall;
  assign in_rdy = e_adv;

  always_comb begin
    logic signed [RW-1:0] lx;
    logic signed [RW-1:0] ly;
    logic signed [RW-1:0] hx;
    logic signed [RW-1:0] hy;
    lx = ybb_pkg::LIMIT_HI;
    ly = ybb_pkg::LIMIT_HI;
    hx = ybb_pkg::LIMIT_LO;
    hy = ybb_pkg::LIMIT_LO;
    for (int k = 0; k < 4; k++) begin
      if ($signed(in_word.rx[k]) < lx) begin
        lx = $signed(in_word.rx[k]);
      end
      if ($signed(in_word.rx[k]) > hx) begin
        hx = $signed(in_word.rx[k]);
      end
      if ($signed(in_word.ry[k]) < ly) begin
        ly = $signed(in_word.ry[k]);
      end
      if ($signed(in_word.ry[k]) > hy) begin
        hy = $signed(in_word.ry[k]);
      end
    end
    e_word_nxt.low_x  = sat(lx);
    e_word_nxt.low_y  = sat(ly);
    e_word_nxt.high_x = sat(hx);
    e_word_nxt.high_y = sat(hy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (e_adv) begin
      e_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (e_adv && in_vld) begin
      e_word_r <= e_word_nxt;
    end
  end

  assign out_valid = e_vld_r;
  assign out_word  = e_word_r;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int COORD_WIDTH = ybb_pkg::COORD_WIDTH;
  localparam int FRAC_BITS   = ybb_pkg::FRAC_BITS;
  localparam int ANGLE_BITS  = ybb_pkg::ANGLE_BITS;

  localparam int TABLE_DEPTH = 256;
  // Rotation uses a quarter wave of TABLE_DEPTH + 1 entries, Q1.15
  localparam longint PI_Q30 = 64'd3373259426;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_BOXES = 1700;
  localparam int COORD_MAX = (2 ** (COORD_WIDTH - 1)) - 1;
  localparam int COORD_MIN = -(2 ** (COORD_WIDTH - 1));
  // The 9999-unit cap and floor in coordinate LSBs
  localparam int LIMIT_LSB = ybb_pkg::LIMIT_UNITS * (2 ** FRAC_BITS);

  // Tracks the boxes taken by the block and checks each bounds word that leaves it.
  class bounds_checker;
    longint             quarter_sine[0:TABLE_DEPTH];
    ybb_pkg::out_word_t pending_bounds[$];
    int                 errors;

    function new();
      int i;
      errors = 0;
      for (i = 0; i <= TABLE_DEPTH; i++) begin
        quarter_sine[i] = sine_q15(i);
      end
    endfunction

    // Taylor series in Q30 for the angle i/TABLE_DEPTH of a right angle
    function longint sine_q15(int i);
      longint unsigned ang;
      longint unsigned ang2;
      longint unsigned term;
      longint          acc;
      int              k;
      ang = (longint'(i) * PI_Q30) / (2 * TABLE_DEPTH);
      ang2 = (ang * ang) >> 30;
      term = ang;
      acc = longint'(ang);
      for (k = 1; k <= 6; k++) begin
        term = ((term * ang2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      acc = (acc + 16384) >>> 15;
      if (acc > 32768) begin
        acc = 32768;
      end
      return acc;
    endfunction

    function logic signed [COORD_WIDTH-1:0] sat_coord(longint val);
      if (val > COORD_MAX) begin
        return COORD_WIDTH'(COORD_MAX);
      end
      if (val < COORD_MIN) begin
        return COORD_WIDTH'(COORD_MIN);
      end
      return COORD_WIDTH'(val);
    endfunction

    // Bounds of the four corners after rotation by the yaw angle
    function ybb_pkg::out_word_t rotated_bounds(ybb_pkg::in_word_t w);
      logic [ANGLE_BITS-1:0] ang;
      ybb_pkg::quad_t        quad;
      longint                pos;
      longint                idx;
      longint                sn;
      longint                cs;
      longint                xs[2];
      longint                ys[2];
      longint                lx;
      longint                ly;
      longint                hx;
      longint                hy;
      longint                rx;
      longint                ry;
      ybb_pkg::out_word_t    res;
      int                    i;
      int                    j;
      ang = w.yaw_angle;
      quad = ybb_pkg::quad_t'(ang[ANGLE_BITS-1 -: 2]);
      pos = longint'(ang[ANGLE_BITS-3:0]);
      idx = (pos * TABLE_DEPTH + (longint'(1) << (ANGLE_BITS - 3))) >> (ANGLE_BITS - 2);
      if (idx > TABLE_DEPTH) begin
        idx = TABLE_DEPTH;
      end
      case (quad)
        ybb_pkg::QUAD_0: begin
          sn = quarter_sine[idx];
          cs = quarter_sine[TABLE_DEPTH - idx];
        end
        ybb_pkg::QUAD_1: begin
          sn = quarter_sine[TABLE_DEPTH - idx];
          cs = -quarter_sine[idx];
        end
        ybb_pkg::QUAD_2: begin
          sn = -quarter_sine[idx];
          cs = -quarter_sine[TABLE_DEPTH - idx];
        end
        default: begin
          sn = -quarter_sine[TABLE_DEPTH - idx];
          cs = quarter_sine[idx];
        end
      endcase
      xs[0] = longint'(w.min_x);
      ys[0] = longint'(w.min_y);
      xs[1] = longint'(w.max_x);
      ys[1] = longint'(w.max_y);
      lx = LIMIT_LSB;
      ly = LIMIT_LSB;
      hx = -LIMIT_LSB;
      hy = -LIMIT_LSB;
      for (i = 0; i < 2; i++) begin
        for (j = 0; j < 2; j++) begin
          // round half up: floor((r + 2^14) / 2^15)
          rx = (cs * xs[i] - sn * ys[j] + 16384) >>> 15;
          ry = (sn * xs[i] + cs * ys[j] + 16384) >>> 15;
          if (rx < lx) lx = rx;
          if (rx > hx) hx = rx;
          if (ry < ly) ly = ry;
          if (ry > hy) hy = ry;
        end
      end
      res.low_x = sat_coord(lx);
      res.low_y = sat_coord(ly);
      res.high_x = sat_coord(hx);
      res.high_y = sat_coord(hy);
      return res;
    endfunction

    // A word without a box is dropped by the block, so nothing is queued for it
    function void note_box(ybb_pkg::in_word_t w);
      if (w.box_found) begin
        pending_bounds.push_back(rotated_bounds(w));
      end
    endfunction

    function void check_bounds(ybb_pkg::out_word_t got);
      ybb_pkg::out_word_t exp;
      if (pending_bounds.size() == 0) begin
        $error("bounds word with no box pending: %0d %0d %0d %0d",
               got.low_x, got.low_y, got.high_x, got.high_y);
        errors++;
        return;
      end
      exp = pending_bounds.pop_front();
      if (got.low_x !== exp.low_x) begin
        $error("low_x: expected %0d, actual %0d", exp.low_x, got.low_x);
        errors++;
      end
      if (got.low_y !== exp.low_y) begin
        $error("low_y: expected %0d, actual %0d", exp.low_y, got.low_y);
        errors++;
      end
      if (got.high_x !== exp.high_x) begin
        $error("high_x: expected %0d, actual %0d", exp.high_x, got.high_x);
        errors++;
      end
      if (got.high_y !== exp.high_y) begin
        $error("high_y: expected %0d, actual %0d", exp.high_y, got.high_y);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  ybb_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ybb_pkg::out_word_t out_word;

  // calm: no gaps on either side; draining: stop stalling the result side
  bit            calm = 1'b0;
  bit            draining = 1'b0;
  int            cycle_count = 0;
  bounds_checker checker_h;

  yaw_rotated_bounding_box #(
    .SINE_TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_run();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 40);
    return $urandom_range(0, 6);
  endfunction

  // Coordinates: extremes, full range, near the 9999-unit limit, or small
  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = COORD_MIN;
          1: v = COORD_MAX;
          2: v = 0;
          default: v = -1;
        endcase
      end
      1, 2, 3: return COORD_WIDTH'($urandom);
      4, 5, 6: begin
        v = LIMIT_LSB + int'($urandom_range(0, 4000)) - 2000;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = int'($urandom_range(0, 8000)) - 4000;
    endcase
    return COORD_WIDTH'(v);
  endfunction

  function automatic logic [ANGLE_BITS-1:0] rand_angle();
    int v;
    if ($urandom_range(0, 4) != 0) return ANGLE_BITS'($urandom);
    // land on or next to a quadrant edge
    v = int'($urandom_range(0, 3)) * (2 ** (ANGLE_BITS - 2)) + int'($urandom_range(0, 6)) - 3;
    return ANGLE_BITS'(v);
  endfunction

  function automatic ybb_pkg::in_word_t make_box(logic found, int ang, int mnx, int mny,
                                                 int mxx, int mxy);
    ybb_pkg::in_word_t w;
    w.box_found = found;
    w.yaw_angle = ANGLE_BITS'(ang);
    w.min_x = COORD_WIDTH'(mnx);
    w.min_y = COORD_WIDTH'(mny);
    w.max_x = COORD_WIDTH'(mxx);
    w.max_y = COORD_WIDTH'(mxy);
    return w;
  endfunction

  // Ordered corners most of the time; the rest keep whatever order they got
  function automatic ybb_pkg::in_word_t rand_box();
    ybb_pkg::in_word_t             w;
    logic signed [COORD_WIDTH-1:0] a;
    logic signed [COORD_WIDTH-1:0] b;
    bit                            ordered;
    ordered = ($urandom_range(0, 99) < 85);
    w.box_found = ($urandom_range(0, 9) != 0);
    w.yaw_angle = rand_angle();
    a = rand_coord();
    b = rand_coord();
    w.min_x = (ordered && a > b) ? b : a;
    w.max_x = (ordered && a > b) ? a : b;
    a = rand_coord();
    b = rand_coord();
    w.min_y = (ordered && a > b) ? b : a;
    w.max_y = (ordered && a > b) ? a : b;
    return w;
  endfunction

  // Offer one word after a random gap and hold it until the block takes it.
  // Returns on the edge that took the word, with in_valid still high.
  task automatic send_box(ybb_pkg::in_word_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Result side back-pressure: runs of free cycles broken by stalls
  initial begin
    bit          stall_now;
    int unsigned hold;
    int unsigned g;
    stall_now = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
      end else if (stall_now) begin
        stall_now = 1'b0;
        hold = pick_run();
      end else begin
        g = pick_gap();
        if (g != 0) begin
          stall_now = 1'b1;
          hold = g - 1;
        end else begin
          hold = pick_run();
        end
      end
      out_stall <= stall_now && !draining;
    end
  end

  // Sample both handshakes on the edge that completes them
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) checker_h.note_box(in_word);
      if (out_valid && !out_stall) checker_h.check_bounds(out_word);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int taken;
    checker_h = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: dropped words, extremes, quadrant edges, table index rounding,
    // the cap and floor, swapped corners, saturation
    send_box(make_box(1'b0, 0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
    send_box(make_box(1'b1, 0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
    send_box(make_box(1'b1, 8192, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
    send_box(make_box(1'b1, 8192, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_box(make_box(1'b1, 40960, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    send_box(make_box(1'b1, 16384, -1600, -800, 1600, 800));
    send_box(make_box(1'b1, 32768, -1600, -800, 1600, 800));
    send_box(make_box(1'b1, 49152, -1600, -800, 1600, 800));
    send_box(make_box(1'b1, 65535, -1600, -800, 1600, 800));
    send_box(make_box(1'b1, 1, -1600, -800, 1600, 800));
    send_box(make_box(1'b1, 31, 100000, -5, 100001, 3));
    send_box(make_box(1'b1, 32, 100000, -5, 100001, 3));
    send_box(make_box(1'b1, 16383, 300000, 300000, 400000, 400000));
    send_box(make_box(1'b0, 12345, 10, 10, 20, 20));
    // box far in the positive corner: the low bounds stop at the cap
    send_box(make_box(1'b1, 0, 200000, 200000, 300000, 300000));
    // box far in the negative corner: the high bounds stop at the floor
    send_box(make_box(1'b1, 0, -300000, -300000, -200000, -200000));
    send_box(make_box(1'b1, 0, LIMIT_LSB, LIMIT_LSB, LIMIT_LSB + 1, LIMIT_LSB + 1));
    // swapped corners rotate as given
    send_box(make_box(1'b1, 5000, 4000, 3000, -4000, -3000));
    send_box(make_box(1'b1, 24576, 0, 0, 0, 0));
    send_box(make_box(1'b1, 57344, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
    send_box(make_box(1'b1, 45000, -1, -1, 0, 0));

    // Random words, with and without a box, all counted toward the total
    taken = 0;
    while (taken < RANDOM_BOXES) begin
      ybb_pkg::in_word_t w;
      w = rand_box();
      if (taken % 250 == 0) calm = ($urandom_range(0, 2) == 0);
      send_box(w);
      taken++;
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // Drain, then keep the clock running for anything unexpected to show up
    draining = 1'b1;
    while (checker_h.pending_bounds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (checker_h.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/ybb_pkg.sv
hdl/ybb_angle.sv
hdl/ybb_rotate.sv
hdl/ybb_bounds.sv
hdl/yaw_rotated_bounding_box.sv
tb/tb_top.sv
